/* rtl/kra_pkg.sv */
// kra_pkg: shared types and constants of the key remap LRU allocator.
// No dependencies; imported by kra_cell, key_remap_lru_allocator and tb.
package kra_pkg;

  localparam int unsigned VirtualKeysDef  = 64;
  localparam int unsigned PhysicalKeysDef = 16;

  // limit register
  localparam int unsigned    CfgW     = 5;
  localparam logic [CfgW-1:0] LimitRst = CfgW'(16);

  localparam logic OpBegin = 1'b0;
  localparam logic OpEnd   = 1'b1;

  typedef enum logic [2:0] {
    StHit   = 3'd0,
    StNew   = 3'd1,
    StEvict = 3'd2,
    StRetry = 3'd3,
    StEnd   = 3'd4
  } kra_status_e;

  // broadcast to every cell of the recency chain
  typedef struct packed {
    logic move;  // cells at or below pos take their neighbor's entry
    logic clr;   // matching cell drops its busy mark
  } kra_ctl_t;

endpackage

/* rtl/kra_cell.sv */
// kra_cell: one slot of the recency chain (slot 0 is most recent).
// Holds one mapping and takes its lower neighbor's mapping on a move.
// Depends on kra_pkg.
module kra_cell import kra_pkg::*; #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned VK_W  = 6,
  parameter int unsigned PK_W  = 4,
  parameter int unsigned POS_W = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  kra_ctl_t         ctl_i,
  input  logic [POS_W-1:0] pos_i,
  input  logic [VK_W-1:0]  key_i,
  input  logic             in_valid_i,
  input  logic             in_busy_i,
  input  logic [VK_W-1:0]  in_vkey_i,
  input  logic [PK_W-1:0]  in_pkey_i,
  output logic             out_valid_o,
  output logic             out_busy_o,
  output logic [VK_W-1:0]  out_vkey_o,
  output logic [PK_W-1:0]  out_pkey_o,
  output logic             match_o,
  output logic             cand_o
);

  localparam logic [POS_W:0] MyPos = (POS_W+1)'(IDX);

  logic            valid_q, busy_q;
  logic [VK_W-1:0] vkey_q;
  logic [PK_W-1:0] pkey_q;
  logic            take;

  assign take    = ctl_i.move && ({1'b0, pos_i} >= MyPos);
  assign match_o = valid_q && (vkey_q == key_i);
  assign cand_o  = valid_q && !busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      busy_q  <= 1'b0;
    end else if (take) begin
      valid_q <= in_valid_i;
      busy_q  <= in_busy_i;
    end else if (ctl_i.clr && match_o) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      vkey_q <= in_vkey_i;
      pkey_q <= in_pkey_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_busy_o  = busy_q;
  assign out_vkey_o  = vkey_q;
  assign out_pkey_o  = pkey_q;

endmodule

/* rtl/key_remap_lru_allocator.sv */
// key_remap_lru_allocator: maps virtual keys onto a pool of physical keys,
// LRU replacement with pinning. Depends on kra_pkg and kra_cell.
//
//  channel   ports                                  direction  handshake
//  request   operation_i, virtual_key_i             in         start / busy
//  result    status_o, physical_key_o, evicted_key_o out       done_o strobe
//  config    cfg_wdata_i (physical key limit)       in         cfg_we_i
//
// A request is taken when start is high and busy is low. busy then stays
// high while the chain is searched and updated; the result word shows on the
// following cycle with done_o. No new request is taken while busy is high.
// The recency chain (one cell per physical key) does the lookup, victim
// pick and move-to-front while busy is high. Reset empties the chain at once.
// Results cannot be stalled; each is shown for one cycle only.
module key_remap_lru_allocator import kra_pkg::*; #(
  parameter int unsigned VIRTUAL_KEYS  = VirtualKeysDef,
  parameter int unsigned PHYSICAL_KEYS = PhysicalKeysDef,
  localparam int unsigned VkW  = (VIRTUAL_KEYS > 1) ? $clog2(VIRTUAL_KEYS) : 1,
  localparam int unsigned PkW  = (PHYSICAL_KEYS > 1) ? $clog2(PHYSICAL_KEYS) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  logic            operation_i,
  input  logic [VkW-1:0]  virtual_key_i,
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_wdata_i,
  output logic            done_o,
  output logic [2:0]      status_o,
  output logic [PkW-1:0]  physical_key_o,
  output logic [VkW-1:0]  evicted_key_o
);

  localparam int unsigned CntW = $clog2(PHYSICAL_KEYS + 1);
  localparam int unsigned CmpW = (CntW > CfgW) ? CntW : CfgW;
  localparam logic [VkW:0]    VkLim  = (VkW+1)'(VIRTUAL_KEYS);
  localparam logic [CntW-1:0] PkFull = CntW'(PHYSICAL_KEYS);

  logic            exec_q, done_q;
  logic            op_q;
  logic [VkW-1:0]  vk_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CfgW-1:0] limit_q;
  kra_status_e     status_q, status_d;
  logic [PkW-1:0]  pkey_q, pkey_d;
  logic [VkW-1:0]  evk_q, evk_d;

  // chain wiring
  logic [PHYSICAL_KEYS-1:0] c_valid, c_busy, match, cand;
  logic [VkW-1:0]           c_vkey [PHYSICAL_KEYS];
  logic [PkW-1:0]           c_pkey [PHYSICAL_KEYS];

  kra_ctl_t       ctl;
  logic [PkW-1:0] pos, hit_pos, vic_pos, head_pkey;
  logic           hit, in_range, new_ok;

  for (genvar g = 0; g < PHYSICAL_KEYS; g++) begin : g_cell
    logic           nb_valid, nb_busy;
    logic [VkW-1:0] nb_vkey;
    logic [PkW-1:0] nb_pkey;
    if (g == 0) begin : g_head
      assign nb_valid = 1'b1;
      assign nb_busy  = 1'b1;
      assign nb_vkey  = vk_q;
      assign nb_pkey  = head_pkey;
    end else begin : g_link
      assign nb_valid = c_valid[g-1];
      assign nb_busy  = c_busy[g-1];
      assign nb_vkey  = c_vkey[g-1];
      assign nb_pkey  = c_pkey[g-1];
    end
    kra_cell #(
      .IDX  (g),
      .VK_W (VkW),
      .PK_W (PkW),
      .POS_W(PkW)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .pos_i      (pos),
      .key_i      (vk_q),
      .in_valid_i (nb_valid),
      .in_busy_i  (nb_busy),
      .in_vkey_i  (nb_vkey),
      .in_pkey_i  (nb_pkey),
      .out_valid_o(c_valid[g]),
      .out_busy_o (c_busy[g]),
      .out_vkey_o (c_vkey[g]),
      .out_pkey_o (c_pkey[g]),
      .match_o    (match[g]),
      .cand_o     (cand[g])
    );
  end

  // hit is unique; victim is the deepest idle slot (least recent)
  always_comb begin
    hit_pos = '0;
    vic_pos = '0;
    for (int i = 0; i < PHYSICAL_KEYS; i++) begin
      if (match[i]) hit_pos = hit_pos | PkW'(i);
      if (cand[i])  vic_pos = PkW'(i);
    end
  end

  assign hit      = |match;
  assign in_range = {1'b0, vk_q} < VkLim;
  assign new_ok   = (CmpW'(cnt_q) < CmpW'(limit_q)) && (cnt_q < PkFull);

  always_comb begin
    ctl       = '{move: 1'b0, clr: 1'b0};
    pos       = '0;
    head_pkey = '0;
    cnt_d     = cnt_q;
    status_d  = StRetry;
    pkey_d    = '0;
    evk_d     = '0;
    if (exec_q) begin
      priority if (op_q == OpEnd) begin
        ctl.clr  = in_range;
        status_d = StEnd;
      end else if (!in_range) begin
        status_d = StRetry;
      end else if (hit) begin
        ctl.move  = 1'b1;
        pos       = hit_pos;
        head_pkey = c_pkey[hit_pos];
        pkey_d    = head_pkey;
        status_d  = StHit;
      end else if (new_ok) begin
        ctl.move  = 1'b1;
        pos       = cnt_q[PkW-1:0];
        head_pkey = cnt_q[PkW-1:0];
        pkey_d    = head_pkey;
        cnt_d     = cnt_q + CntW'(1);
        status_d  = StNew;
      end else if (|cand) begin
        ctl.move  = 1'b1;
        pos       = vic_pos;
        head_pkey = c_pkey[vic_pos];
        pkey_d    = head_pkey;
        evk_d     = c_vkey[vic_pos];
        status_d  = StEvict;
      end else begin
        status_d = StRetry;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exec_q  <= 1'b0;
      done_q  <= 1'b0;
      cnt_q   <= '0;
      limit_q <= LimitRst;
    end else begin
      exec_q <= start && !exec_q;
      done_q <= exec_q;
      cnt_q  <= cnt_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !exec_q) begin
      op_q <= operation_i;
      vk_q <= virtual_key_i;
    end
    if (exec_q) begin
      status_q <= status_d;
      pkey_q   <= pkey_d;
      evk_q    <= evk_d;
    end
  end

  assign busy           = exec_q;
  assign done_o         = done_q;
  assign status_o       = status_q;
  assign physical_key_o = pkey_q;
  assign evicted_key_o  = evk_q;

  a_done_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(exec_q))
    else $error("result word without a preceding execute cycle");

  a_exec_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_q |=> !exec_q)
    else $error("execute cycle lasted more than one clock");

  a_count_in_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= PkFull)
    else $error("handed-out count beyond pool size");

  a_chain_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CntW'($countones(c_valid)) == cnt_q)
    else $error("valid slots disagree with handed-out count");

  a_single_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match))
    else $error("virtual key mapped in more than one slot");

endmodule

/* verif/tb.sv */
// tb: self-checking bench for key_remap_lru_allocator. It drives begin and end
// requests, mirrors the key map and LRU stamps in a tracker, and checks each word.
// Depends on kra_pkg and the allocator RTL.
`timescale 1ns / 1ps

import kra_pkg::*;

typedef struct {
  kra_status_e status;
  bit [3:0]    pkey;
  bit [5:0]    ekey;
} key_word_t;

// Mirror of the key map. Computes the word owed for each accepted request and
// holds the words still to come.
class key_map_tracker;
  bit            mapped[VirtualKeysDef];
  bit            pinned[VirtualKeysDef];
  bit [3:0]      pkey_of[VirtualKeysDef];
  bit [63:0]     stamp_of[VirtualKeysDef];
  bit [63:0]     use_count;
  int unsigned   handed_out;
  bit [CfgW-1:0] key_limit;
  key_word_t     expected_words[$];
  int unsigned   mismatches;

  function new();
    key_limit  = LimitRst;
    use_count  = '0;
    handed_out = 0;
    mismatches = 0;
  endfunction

  function void set_limit(bit [CfgW-1:0] value);
    key_limit = value;
  endfunction

  function void take_key(bit [5:0] vk, bit [3:0] pk);
    mapped[vk]   = 1'b1;
    pinned[vk]   = 1'b1;
    pkey_of[vk]  = pk;
    stamp_of[vk] = use_count;
    use_count++;
  endfunction

  function void record_request(bit op, bit [5:0] vk);
    key_word_t   w;
    int unsigned lim;
    int          victim;
    w = '{status: StEnd, pkey: 4'd0, ekey: 6'd0};
    lim = (key_limit > PhysicalKeysDef) ? PhysicalKeysDef : key_limit;
    if (op == OpEnd) begin
      pinned[vk] = 1'b0;
    end else if (mapped[vk]) begin
      pinned[vk]   = 1'b1;
      stamp_of[vk] = use_count;
      use_count++;
      w.status = StHit;
      w.pkey   = pkey_of[vk];
    end else if (handed_out < lim) begin
      take_key(vk, handed_out[3:0]);
      handed_out++;
      w.status = StNew;
      w.pkey   = pkey_of[vk];
    end else begin
      // oldest unpinned mapping; strict compare keeps the lowest index on ties
      victim = -1;
      for (int i = 0; i < VirtualKeysDef; i++) begin
        if (mapped[i] && !pinned[i] && (victim < 0 || stamp_of[i] < stamp_of[victim]))
          victim = i;
      end
      if (victim < 0) begin
        w.status = StRetry;
      end else begin
        mapped[victim] = 1'b0;
        take_key(vk, pkey_of[victim]);
        w.status = StEvict;
        w.pkey   = pkey_of[vk];
        w.ekey   = victim[5:0];
      end
    end
    expected_words.push_back(w);
  endfunction

  function void flag(string msg);
    mismatches++;
    if (mismatches <= 10) $display("tb: mismatch: %s", msg);
  endfunction

  function void check_word(logic [2:0] st, logic [3:0] pk, logic [5:0] ek);
    key_word_t w;
    if (expected_words.size() == 0) begin
      flag($sformatf("unexpected word status=%0d pkey=%0d ekey=%0d", st, pk, ek));
      return;
    end
    w = expected_words.pop_front();
    if (st !== w.status || pk !== w.pkey || ek !== w.ekey)
      flag($sformatf("expected status=%s pkey=%0d ekey=%0d, got status=%0d pkey=%0d ekey=%0d",
                     w.status.name(), w.pkey, w.ekey, st, pk, ek));
  endfunction
endclass

module tb;
  localparam int unsigned RunLimit = 300000;

  logic            clk_i         = 1'b0;
  logic            rst_ni        = 1'b0;
  logic            start         = 1'b0;
  logic            operation_i   = OpBegin;
  logic [5:0]      virtual_key_i = '0;
  logic            cfg_we_i      = 1'b0;
  logic [CfgW-1:0] cfg_wdata_i   = LimitRst;
  logic            busy;
  logic            done_o;
  logic [2:0]      status_o;
  logic [3:0]      physical_key_o;
  logic [5:0]      evicted_key_o;

  key_map_tracker tracker = new();

  key_remap_lru_allocator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .operation_i    (operation_i),
    .virtual_key_i  (virtual_key_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .physical_key_o (physical_key_o),
    .evicted_key_o  (evicted_key_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // check before record: a word leaving and a request arriving may share an edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) tracker.check_word(status_o, physical_key_o, evicted_key_o);
      if (start && !busy) tracker.record_request(operation_i, virtual_key_i);
    end
  end

  initial begin
    repeat (RunLimit) @(posedge clk_i);
    $display("tb: failure");
    $finish;
  end

  // returns at the edge that takes the word; start stays high for a follow-on
  task automatic send_word(logic op, logic [5:0] vk);
    start         <= 1'b1;
    operation_i   <= op;
    virtual_key_i <= vk;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic pause(int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // wait out every owed word, then let the bench idle before returning
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk_i); while (tracker.expected_words.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [CfgW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    tracker.set_limit(value);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic random_run(int unsigned n, int unsigned span);
    int unsigned burst;
    int unsigned gap;
    logic        op;
    logic [5:0]  vk;
    burst = 0;
    for (int i = 0; i < n; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 30);
        gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap != 0) pause(gap);
      end
      op = ($urandom_range(0, 99) < 55) ? OpBegin : OpEnd;
      if ($urandom_range(0, 3) == 0) vk = 6'($urandom_range(0, 63));
      else vk = 6'($urandom_range(0, span - 1));
      send_word(op, vk);
      burst--;
    end
    settle();
  endtask

  initial begin
    logic [CfgW-1:0] plan[8];
    plan = '{5'd4, 5'd8, 5'd17, 5'd31, 5'd16, 5'd1, 5'd0, 5'd16};

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero limit with an empty map: nothing to hand out, nothing to evict
    write_limit(5'd0);
    send_word(OpBegin, 6'd5);
    send_word(OpEnd, 6'd5);
    settle();

    // single key: pinned entry blocks eviction until released
    write_limit(5'd1);
    send_word(OpBegin, 6'd5);
    send_word(OpBegin, 6'd9);
    send_word(OpEnd, 6'd5);
    send_word(OpBegin, 6'd9);
    send_word(OpBegin, 6'd5);
    send_word(OpEnd, 6'd9);
    send_word(OpBegin, 6'd0);
    settle();

    // limit above the pool acts as the pool size
    write_limit(5'd31);
    send_word(OpBegin, 6'd63);
    send_word(OpBegin, 6'd42);
    send_word(OpBegin, 6'd21);
    send_word(OpEnd, 6'd63);
    send_word(OpEnd, 6'd33);
    send_word(OpBegin, 6'd63);
    send_word(OpBegin, 6'd63);
    send_word(OpEnd, 6'd42);
    send_word(OpEnd, 6'd21);
    send_word(OpEnd, 6'd63);
    send_word(OpEnd, 6'd0);
    settle();

    for (int p = 0; p < 8; p++) begin
      write_limit(plan[p]);
      random_run(205, (p % 2 == 0) ? 12 : 40);
    end

    repeat (8) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.expected_words.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end
endmodule

/* sim.f */
rtl/kra_pkg.sv
rtl/kra_cell.sv
rtl/key_remap_lru_allocator.sv
verif/tb.sv
